// File: sv/abg_pkg.sv
// Package for the adaptive breakpoint grouping block: widths, register map,
// shared types and small helper functions. No dependencies.
package abg_pkg;

    localparam int COORD_W    = 20;
    localparam int MAX_POINTS = 4096;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int RNG_W      = COORD_W;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_IN_W    = 2 * DIFF_W;
    localparam int SQ_OUT_W   = DIFF_W;
    localparam int MUL_W      = 64;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

    localparam int GAP_W   = 19;
    localparam int PROP_W  = 16;
    localparam int SINE_W  = 16;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    localparam logic [1:0] REG_MAX_GAP    = 2'd0;
    localparam logic [1:0] REG_GAP_PROP   = 2'd1;
    localparam logic [1:0] REG_SINE_LIMIT = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic                      end_of_scan;
    } item_t;

    typedef struct packed {
        logic [GAP_W-1:0]  max_gap;
        logic [PROP_W-1:0] gap_proportion;
        logic [SINE_W-1:0] sine_limit;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_MX, ST_MY, ST_RSQ, ST_CHK, ST_MDX, ST_MDY, ST_MG, ST_MT,
        ST_CSQ, ST_HER, ST_MQ1, ST_MQ2, ST_MQ3, ST_MAB, ST_MABL, ST_MLIM,
        ST_CLOSE, ST_EMITA, ST_START, ST_UPD, ST_EMITB
    } state_t;

    // Magnitude of a two's complement coordinate, as an unsigned value.
    function automatic logic [COORD_W-1:0] coord_mag(input logic signed [COORD_W-1:0] v);
        coord_mag = v[COORD_W-1] ? COORD_W'(-v) : COORD_W'(v);
    endfunction

    // Magnitude of s - 2k for the Heron factors.
    function automatic logic [SQ_OUT_W+1:0] heron_mag(input logic [SQ_OUT_W+1:0] s,
                                                       input logic [SQ_OUT_W+1:0] k2);
        heron_mag = (s >= k2) ? (s - k2) : (k2 - s);
    endfunction

endpackage

// File: sv/abg_front.sv
// Front end: accepts input transfers into a short queue ahead of the engine.
// Depends on abg_pkg.
module abg_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [abg_pkg::IN_DATA_W-1:0]   s_tdata,  // pos_x, pos_y
    input  logic                            s_tlast,  // end_of_scan
    output logic                            q_valid,
    output abg_pkg::item_t                  q_item,
    input  logic                            q_pop
);
    import abg_pkg::*;

    item_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic                push;
    logic                pop;

    assign s_tready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg].pos_x       <= s_tdata[COORD_W-1:0];
            entry_reg[wr_ptr_reg].pos_y       <= s_tdata[2*COORD_W-1:COORD_W];
            entry_reg[wr_ptr_reg].end_of_scan <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: sv/abg_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle, stops early once
// the remaining multiplier bits are zero. Depends on abg_pkg.
module abg_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [abg_pkg::MUL_W-1:0]   op_a,
    input  logic [abg_pkg::MUL_W-1:0]   op_b,
    output logic                        done,
    output logic [abg_pkg::PROD_W-1:0]  product
);
    import abg_pkg::*;

    logic [PROD_W-1:0] acc_reg;
    logic [PROD_W-1:0] a_reg;
    logic [MUL_W-1:0]  b_reg;
    logic              busy_reg;
    logic              done_reg;

    assign done    = done_reg;
    assign product = acc_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= PROD_W'(op_a);
            b_reg   <= op_b;
        end
        else if (busy_reg && (b_reg != '0))
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg && (b_reg == '0))
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

endmodule

// File: sv/abg_sqrt.sv
// Integer square root, floor result, one result bit per cycle.
// Depends on abg_pkg.
module abg_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [abg_pkg::SQ_IN_W-1:0]   value,
    output logic                          done,
    output logic [abg_pkg::SQ_OUT_W-1:0]  root
);
    import abg_pkg::*;

    logic [SQ_IN_W-1:0] rem_reg;
    logic [SQ_IN_W-1:0] root_reg;
    logic [SQ_IN_W-1:0] bit_reg;
    logic [SQ_IN_W-1:0] trial;
    logic               busy_reg;
    logic               done_reg;

    assign trial = root_reg + bit_reg;
    assign done  = done_reg;
    assign root  = root_reg[SQ_OUT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= value;
            root_reg <= '0;
            bit_reg  <= SQ_IN_W'(1) << (SQ_IN_W - 2);
        end
        else if (busy_reg && (bit_reg != '0))
        begin
            if (rem_reg >= trial)
            begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg && (bit_reg == '0))
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

endmodule

// File: sv/abg_engine.sv
// Back end: sequences the range, gap, threshold and Heron products over a
// shared multiplier and square root unit, keeps the group state and drives
// the output register. Depends on abg_pkg, abg_mul and abg_sqrt.
module abg_engine (
    input  logic                             clk,
    input  logic                             rst_n,
    input  abg_pkg::cfg_t                    cfg,
    input  logic                             q_valid,
    input  abg_pkg::item_t                   q_item,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [abg_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                             m_tlast
);
    import abg_pkg::*;

    localparam int HW = SQ_OUT_W + 2;

    state_t state_reg;
    state_t state_next;

    item_t                 item_reg;
    logic [2*RNG_W-1:0]    r2_reg;
    logic [RNG_W-1:0]      rng_reg;
    logic [SQ_IN_W-1:0]    d2_reg;
    logic [DIFF_W-1:0]     t_reg;
    logic [SQ_OUT_W-1:0]   c_reg;
    logic [HW-1:0]         s_reg;
    logic [HW-1:0]         f2_reg;
    logic [HW-1:0]         f3_reg;
    logic [HW-1:0]         f4_reg;
    logic                  neg_reg;
    logic [2*HW-1:0]       p1_reg;
    logic [2*HW-1:0]       p2_reg;
    logic [PROD_W-1:0]     q_reg;
    logic [2*RNG_W-1:0]    ab_reg;
    logic [2*RNG_W+SINE_W-1:0] abl_reg;
    logic [PROD_W-1:0]     lim_reg;
    logic                  new_vis_reg;
    logic                  req_reg;

    logic signed [COORD_W-1:0] prev_x_reg;
    logic signed [COORD_W-1:0] prev_y_reg;
    logic [RNG_W-1:0]      last_range_reg;
    logic [IDX_W-1:0]      group_start_reg;
    logic [CNT_W-1:0]      group_size_reg;
    logic                  group_vis_reg;
    logic [IDX_W-1:0]      next_index_reg;
    logic                  in_scan_reg;

    logic                  out_valid_reg;
    logic [IDX_W-1:0]      out_first_reg;
    logic [IDX_W-1:0]      out_final_reg;
    logic [CNT_W-1:0]      out_count_reg;
    logic                  out_vis_reg;
    logic                  out_done_reg;

    logic                  mul_start;
    logic [MUL_W-1:0]      mul_a;
    logic [MUL_W-1:0]      mul_b;
    logic                  mul_done;
    logic [PROD_W-1:0]     mul_p;
    logic                  sq_start;
    logic [SQ_IN_W-1:0]    sq_v;
    logic                  sq_done;
    logic [SQ_OUT_W-1:0]   sq_root;

    logic [COORD_W-1:0]    ax;
    logic [COORD_W-1:0]    ay;
    logic [DIFF_W-1:0]     dx;
    logic [DIFF_W-1:0]     dy;
    logic signed [DIFF_W-1:0] dx_s;
    logic signed [DIFF_W-1:0] dy_s;
    logic                  join_grp;
    logic                  out_free;
    logic                  out_load;
    logic [IDX_W+1:0]      last_sum;
    logic [IDX_W-1:0]      last_idx;
    logic [HW-1:0]         s_sum;
    logic [PROD_W-1:0]     q_shift;
    logic                  below;
    logic                  above;
    logic                  nearer;
    logic                  use_mul;
    logic                  use_sqrt;

    abg_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    abg_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (sq_v),
        .done  (sq_done),
        .root  (sq_root)
    );

    assign ax   = coord_mag(item_reg.pos_x);
    assign ay   = coord_mag(item_reg.pos_y);
    assign dx_s = DIFF_W'(item_reg.pos_x) - DIFF_W'(prev_x_reg);
    assign dy_s = DIFF_W'(item_reg.pos_y) - DIFF_W'(prev_y_reg);
    assign dx   = dx_s[DIFF_W-1] ? DIFF_W'(-dx_s) : DIFF_W'(dx_s);
    assign dy   = dy_s[DIFF_W-1] ? DIFF_W'(-dy_s) : DIFF_W'(dy_s);

    assign join_grp = (d2_reg < mul_p[SQ_IN_W-1:0]);
    assign out_free = !out_valid_reg || m_tready;
    assign out_load = ((state_reg == ST_EMITA) || (state_reg == ST_EMITB)) && out_free;

    assign s_sum = HW'(rng_reg) + HW'(last_range_reg) + HW'(c_reg);

    // The Heron product is scaled by 2^30 to compare with the squared sine limit.
    assign q_shift = q_reg << 30;
    assign below   = (q_shift < lim_reg);
    assign above   = (lim_reg < q_shift);
    assign nearer  = (rng_reg < last_range_reg);

    assign last_sum = (IDX_W+2)'(group_start_reg) + (IDX_W+2)'(group_size_reg) - 1'b1;
    assign last_idx = (last_sum > (IDX_W+2)'(MAX_POINTS - 1)) ? IDX_W'(MAX_POINTS - 1)
                                                              : last_sum[IDX_W-1:0];

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_done_reg;
    assign m_tdata  = OUT_DATA_W'({out_vis_reg, out_count_reg, out_final_reg, out_first_reg});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (q_valid) state_next = ST_MX;
            ST_MX:    if (mul_done) state_next = ST_MY;
            ST_MY:    if (mul_done) state_next = ST_RSQ;
            ST_RSQ:   if (sq_done) state_next = ST_CHK;
            ST_CHK:   state_next = in_scan_reg ? ST_MDX : ST_START;
            ST_MDX:   if (mul_done) state_next = ST_MDY;
            ST_MDY:   if (mul_done) state_next = ST_MG;
            ST_MG:    if (mul_done) state_next = ST_MT;
            ST_MT:    if (mul_done) state_next = join_grp ? ST_UPD : ST_CSQ;
            ST_CSQ:   if (sq_done) state_next = ST_HER;
            ST_HER:   state_next = ST_MQ1;
            ST_MQ1:   if (mul_done) state_next = ST_MQ2;
            ST_MQ2:   if (mul_done) state_next = ST_MQ3;
            ST_MQ3:   if (mul_done) state_next = ST_MAB;
            ST_MAB:   if (mul_done) state_next = ST_MABL;
            ST_MABL:  if (mul_done) state_next = ST_MLIM;
            ST_MLIM:  if (mul_done) state_next = ST_CLOSE;
            ST_CLOSE: state_next = ST_EMITA;
            ST_EMITA: if (out_free) state_next = ST_UPD;
            ST_START: state_next = ST_UPD;
            ST_UPD:   state_next = item_reg.end_of_scan ? ST_EMITB : ST_IDLE;
            ST_EMITB: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mul_a    = '0;
        mul_b    = '0;
        sq_v     = '0;
        use_mul  = 1'b0;
        use_sqrt = 1'b0;
        q_pop    = (state_reg == ST_IDLE) && q_valid;
        case (state_reg)
            ST_MX:   begin use_mul = 1'b1; mul_a = MUL_W'(ax); mul_b = MUL_W'(ax); end
            ST_MY:   begin use_mul = 1'b1; mul_a = MUL_W'(ay); mul_b = MUL_W'(ay); end
            ST_RSQ:  begin use_sqrt = 1'b1; sq_v = SQ_IN_W'(r2_reg); end
            ST_MDX:  begin use_mul = 1'b1; mul_a = MUL_W'(dx); mul_b = MUL_W'(dx); end
            ST_MDY:  begin use_mul = 1'b1; mul_a = MUL_W'(dy); mul_b = MUL_W'(dy); end
            ST_MG:   begin use_mul = 1'b1; mul_a = MUL_W'(rng_reg);
                           mul_b = MUL_W'(cfg.gap_proportion); end
            ST_MT:   begin use_mul = 1'b1; mul_a = MUL_W'(t_reg); mul_b = MUL_W'(t_reg); end
            ST_CSQ:  begin use_sqrt = 1'b1; sq_v = d2_reg; end
            ST_MQ1:  begin use_mul = 1'b1; mul_a = MUL_W'(s_reg); mul_b = MUL_W'(f2_reg); end
            ST_MQ2:  begin use_mul = 1'b1; mul_a = MUL_W'(f3_reg); mul_b = MUL_W'(f4_reg); end
            ST_MQ3:  begin use_mul = 1'b1; mul_a = MUL_W'(p1_reg); mul_b = MUL_W'(p2_reg); end
            ST_MAB:  begin use_mul = 1'b1; mul_a = MUL_W'(rng_reg);
                           mul_b = MUL_W'(last_range_reg); end
            ST_MABL: begin use_mul = 1'b1; mul_a = MUL_W'(ab_reg);
                           mul_b = MUL_W'(cfg.sine_limit); end
            ST_MLIM: begin use_mul = 1'b1; mul_a = MUL_W'(abl_reg); mul_b = MUL_W'(abl_reg); end
            default: begin end
        endcase
        mul_start = use_mul && !req_reg;
        sq_start  = use_sqrt && !req_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            req_reg         <= 1'b0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            last_range_reg  <= '0;
            group_start_reg <= '0;
            group_size_reg  <= '0;
            group_vis_reg   <= 1'b1;
            next_index_reg  <= '0;
            in_scan_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (mul_start || sq_start)
            begin
                req_reg <= 1'b1;
            end
            else if (mul_done || sq_done)
            begin
                req_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_MT:
                begin
                    if (mul_done && join_grp &&
                        (group_size_reg < CNT_W'(MAX_POINTS)))
                    begin
                        group_size_reg <= group_size_reg + 1'b1;
                    end
                end
                ST_CLOSE:
                begin
                    if (below && nearer)
                    begin
                        group_vis_reg <= 1'b0;
                    end
                end
                ST_EMITA:
                begin
                    if (out_free)
                    begin
                        group_start_reg <= next_index_reg;
                        group_size_reg  <= CNT_W'(1);
                        group_vis_reg   <= new_vis_reg;
                    end
                end
                ST_START:
                begin
                    group_start_reg <= next_index_reg;
                    group_size_reg  <= CNT_W'(1);
                    group_vis_reg   <= 1'b1;
                    in_scan_reg     <= 1'b1;
                end
                ST_UPD:
                begin
                    prev_x_reg     <= item_reg.pos_x;
                    prev_y_reg     <= item_reg.pos_y;
                    last_range_reg <= rng_reg;
                    if (next_index_reg < IDX_W'(MAX_POINTS - 1))
                    begin
                        next_index_reg <= next_index_reg + 1'b1;
                    end
                end
                ST_EMITB:
                begin
                    if (out_free)
                    begin
                        in_scan_reg    <= 1'b0;
                        next_index_reg <= '0;
                    end
                end
                default: begin end
            endcase
        end
    end

    // Datapath and output payload registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:  if (q_valid) item_reg <= q_item;
            ST_MX:    if (mul_done) r2_reg <= mul_p[2*RNG_W-1:0];
            ST_MY:    if (mul_done) r2_reg <= r2_reg + mul_p[2*RNG_W-1:0];
            ST_RSQ:   if (sq_done) rng_reg <= sq_root[RNG_W-1:0];
            ST_MDX:   if (mul_done) d2_reg <= mul_p[SQ_IN_W-1:0];
            ST_MDY:   if (mul_done) d2_reg <= d2_reg + mul_p[SQ_IN_W-1:0];
            ST_MG:    if (mul_done) t_reg <= DIFF_W'(cfg.max_gap) +
                                             DIFF_W'(mul_p[RNG_W+PROP_W-1:PROP_W]);
            ST_CSQ:   if (sq_done) c_reg <= sq_root;
            ST_HER:
            begin
                s_reg   <= s_sum;
                f2_reg  <= heron_mag(s_sum, HW'(rng_reg) << 1);
                f3_reg  <= heron_mag(s_sum, HW'(last_range_reg) << 1);
                f4_reg  <= heron_mag(s_sum, HW'(c_reg) << 1);
                neg_reg <= (s_sum < (HW'(rng_reg) << 1)) ^
                           (s_sum < (HW'(last_range_reg) << 1)) ^
                           (s_sum < (HW'(c_reg) << 1));
            end
            ST_MQ1:   if (mul_done) p1_reg <= mul_p[2*HW-1:0];
            ST_MQ2:   if (mul_done) p2_reg <= mul_p[2*HW-1:0];
            ST_MQ3:   if (mul_done) q_reg <= neg_reg ? '0 : mul_p;
            ST_MAB:   if (mul_done) ab_reg <= mul_p[2*RNG_W-1:0];
            ST_MABL:  if (mul_done) abl_reg <= mul_p[2*RNG_W+SINE_W-1:0];
            ST_MLIM:  if (mul_done) lim_reg <= mul_p;
            ST_CLOSE: new_vis_reg <= above || nearer;
            ST_EMITA, ST_EMITB:
            begin
                if (out_free)
                begin
                    out_first_reg <= group_start_reg;
                    out_final_reg <= last_idx;
                    out_count_reg <= group_size_reg;
                    out_vis_reg   <= group_vis_reg;
                    out_done_reg  <= (state_reg == ST_EMITB);
                end
            end
            default: begin end
        endcase
    end

endmodule

// File: sv/adaptive_breakpoint_grouping.sv
// Top level of the adaptive breakpoint grouping block: configuration
// registers, input queue and grouping engine. Depends on abg_pkg,
// abg_front and abg_engine.
//
//  Channel | Direction | Transfer contents
//  s_*     | in        | one scan point: pos_x, pos_y; tlast = end_of_scan
//  m_*     | out       | one closed group: indices, count, visible; tlast = scan_done
//  APB     | in/out    | max_gap @0x0, gap_proportion @0x4, sine_limit @0x8
//
// A point that opens a scan takes the least time, one that joins the group more
// and one that closes a group the most; the time is set by the shared
// shift-and-add multiplier (one multiplier bit per cycle, fewer for small
// operands) and the bit-serial square root.
// Reset is asynchronous and active low and restores the register defaults.
// A two-entry queue takes points while the engine works; a stalled output
// holds the engine only when a second result is ready.
module adaptive_breakpoint_grouping (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [abg_pkg::IN_DATA_W-1:0]   s_tdata,  // pos_x[19:0], pos_y[39:20]
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // first_index[11:0], final_index[23:12], point_count[36:24], visible[37], zeros
    output logic [abg_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                            m_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [abg_pkg::APB_AW-1:0]      paddr,
    input  logic [abg_pkg::APB_DW-1:0]      pwdata,
    output logic [abg_pkg::APB_DW-1:0]      prdata,
    output logic                            pready
);
    import abg_pkg::*;

    cfg_t       cfg_reg;
    logic       q_valid;
    item_t      q_item;
    logic       q_pop;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_gap        <= GAP_W'(410);
            cfg_reg.gap_proportion <= PROP_W'(412);
            cfg_reg.sine_limit     <= SINE_W'(823);
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                REG_MAX_GAP:    cfg_reg.max_gap        <= pwdata[GAP_W-1:0];
                REG_GAP_PROP:   cfg_reg.gap_proportion <= pwdata[PROP_W-1:0];
                REG_SINE_LIMIT: cfg_reg.sine_limit     <= pwdata[SINE_W-1:0];
                default: begin end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MAX_GAP:    prdata = APB_DW'(cfg_reg.max_gap);
            REG_GAP_PROP:   prdata = APB_DW'(cfg_reg.gap_proportion);
            REG_SINE_LIMIT: prdata = APB_DW'(cfg_reg.sine_limit);
            default:        prdata = '0;
        endcase
    end

    abg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    abg_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
